// ===== design/nws_pkg.sv =====
// shared types and constants for the waveform statistics block
package nws_pkg;
   localparam int TimeBits   = 32;
   localparam int SampleBits = 16;
   localparam int LinBits    = 50;
   localparam int SqBits     = 64;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FEW      = 2'd1,
      STATUS_ZERO_DUR = 2'd2,
      STATUS_BACKWARD = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      DIV_IDLE = 2'd0,
      DIV_RUN  = 2'd1,
      DIV_SQRT = 2'd2,
      DIV_DONE = 2'd3
   } back_state_type;

   // record summary handed from front to back
   typedef struct packed {
      logic signed [15:0] minimum;
      logic signed [15:0] maximum;
      logic signed [LinBits-1:0] lin_sum;
      logic [SqBits-1:0] sq_sum;
      logic [TimeBits-1:0] duration;
      status_type status;
   } record_type;
endpackage

// ===== design/nonuniform_waveform_statistics.sv =====
// top level of the nonuniform waveform statistics block
// path: a sample's products are registered in stage 1 and added to the sums in stage 2
// as the front advances; an ok record then passes the shared divide and the square root,
// an error record goes straight to its result, both after any wait for the back end
// throughput: one sample per cycle inside a record; one record in the back end at a time
// the front stalls only while its finished record waits for the back end
// reset: synchronous active high, clears front sums, counters, valid flags and back state
module nonuniform_waveform_statistics #(
   parameter int TIME_BITS   = nws_pkg::TimeBits,
   parameter int SAMPLE_BITS = nws_pkg::SampleBits
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [31:0] req_sample_time,
   input  logic signed [15:0] req_sample_value,
   input  logic req_last,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [15:0] rsp_minimum,
   output logic signed [15:0] rsp_maximum,
   output logic [15:0] rsp_peak_to_peak,
   output logic signed [15:0] rsp_mean_value,
   output logic [15:0] rsp_rms_value,
   output logic [1:0] rsp_status
);
   // record word between front and back, one-deep queue in the front
   logic rec_valid, rec_stall;
   nws_pkg::record_type rec_data;

   nws_front #(.TIME_BITS(TIME_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_sample_time, .req_sample_value,
      .req_last, .rec_valid, .rec_stall, .rec_data
   );

   nws_back #(.TIME_BITS(TIME_BITS)) u_back (
      .clock, .reset, .rec_valid, .rec_stall, .rec_data, .rsp_valid, .rsp_stall,
      .rsp_minimum, .rsp_maximum, .rsp_peak_to_peak, .rsp_mean_value,
      .rsp_rms_value, .rsp_status
   );

   // a record with an error status gives zero mean and rms
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != nws_pkg::STATUS_OK |-> rsp_mean_value == 16'sd0
         && rsp_rms_value == 16'd0) else $error("error record with nonzero results");
   // peak-to-peak is never negative in the signed sense of the extremes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != nws_pkg::STATUS_FEW |-> rsp_minimum <= rsp_maximum)
      else $error("minimum above maximum");
   // back end never takes a new record while its result word is still offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rec_stall) else $error("back end accepts while busy");
endmodule

// ===== design/nws_front.sv =====
// front end: per-sample min/max tracking and trapezoid accumulation
module nws_front #(
   parameter int TIME_BITS   = nws_pkg::TimeBits,
   parameter int SAMPLE_BITS = nws_pkg::SampleBits
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [31:0] req_sample_time,
   input  logic signed [15:0] req_sample_value,
   input  logic req_last,
   output logic rec_valid,
   input  logic rec_stall,
   output nws_pkg::record_type rec_data
);
   localparam int LB = nws_pkg::LinBits;
   localparam int SB = nws_pkg::SqBits;

   logic [TIME_BITS-1:0] start_ff, start_in, prev_t_ff, prev_t_in;
   logic signed [SAMPLE_BITS-1:0] prev_x_ff, prev_x_in, min_ff, min_in, max_ff, max_in;
   logic [1:0] seen_ff, seen_in;
   logic signed [LB-1:0] lin_ff, lin_in;
   logic [SB-1:0] sq_ff, sq_in;
   logic back_ff, back_in;
   // stage 1 registers: products pending accumulation
   logic p_valid_ff, p_valid_in;
   logic signed [SAMPLE_BITS+1:0] p_xs_ff, p_xs_in;
   logic [2*SAMPLE_BITS+1:0] p_q_ff, p_q_in;
   logic [TIME_BITS-1:0] p_dt_ff, p_dt_in;
   logic p_last_ff, p_last_in;
   logic [1:0] p_seen_ff, p_seen_in;
   logic p_back_ff, p_back_in;
   logic [TIME_BITS-1:0] p_dur_ff, p_dur_in;
   logic signed [SAMPLE_BITS-1:0] p_min_ff, p_min_in, p_max_ff, p_max_in;
   logic out_valid_ff, out_valid_in;
   nws_pkg::record_type out_ff, out_in;

   logic signed [SAMPLE_BITS-1:0] x;
   logic [TIME_BITS-1:0] t;
   logic acc, adv;
   logic signed [2*SAMPLE_BITS+1:0] x0s, x1s;
   logic signed [LB-1:0] lin_next;
   logic [SB-1:0] sq_next;

   assign x = req_sample_value[SAMPLE_BITS-1:0];
   assign t = req_sample_time[TIME_BITS-1:0];
   assign adv = !(out_valid_ff && rec_stall);
   assign req_stall = !adv;
   assign acc = req_valid && adv;
   assign rec_valid = out_valid_ff;
   assign rec_data = out_ff;
   assign x0s = (2*SAMPLE_BITS+2)'(prev_x_ff);
   assign x1s = (2*SAMPLE_BITS+2)'(x);

   always_comb begin
      start_in = start_ff; prev_t_in = prev_t_ff; prev_x_in = prev_x_ff;
      min_in = min_ff; max_in = max_ff; seen_in = seen_ff; back_in = back_ff;
      p_valid_in = 1'b0; p_xs_in = '0; p_q_in = '0; p_dt_in = '0;
      p_last_in = 1'b0; p_seen_in = p_seen_ff; p_back_in = p_back_ff;
      p_dur_in = p_dur_ff; p_min_in = p_min_ff; p_max_in = p_max_ff;
      if (acc) begin
         p_valid_in = 1'b1;
         if (seen_ff == 2'd0) start_in = t;
         else if (t < prev_t_ff) back_in = 1'b1;
         else if (!back_ff) begin
            p_xs_in = (SAMPLE_BITS+2)'(prev_x_ff) + (SAMPLE_BITS+2)'(x);
            p_q_in = (2*SAMPLE_BITS+2)'(x0s*x0s + x0s*x1s + x1s*x1s);
            p_dt_in = t - prev_t_ff;
         end
         if (x < min_ff) min_in = x;
         if (x > max_ff) max_in = x;
         prev_t_in = t; prev_x_in = x;
         if (seen_ff != 2'd2) seen_in = seen_ff + 2'd1;
         p_last_in = req_last; p_seen_in = seen_in; p_back_in = back_in;
         p_dur_in = t - ((seen_ff == 2'd0) ? t : start_ff);
         p_min_in = min_in; p_max_in = max_in;
         if (req_last) begin
            start_in = '0; prev_t_in = '0; prev_x_in = '0; seen_in = '0; back_in = 1'b0;
            min_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            max_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         end
      end else if (!adv) begin
         p_valid_in = p_valid_ff; p_xs_in = p_xs_ff; p_q_in = p_q_ff; p_dt_in = p_dt_ff;
         p_last_in = p_last_ff;
      end
   end

   // stage 2: accumulate products
   assign lin_next = lin_ff + LB'(p_xs_ff * $signed({1'b0, p_dt_ff}));
   assign sq_next  = sq_ff + SB'(p_q_ff * p_dt_ff);

   always_comb begin
      lin_in = lin_ff; sq_in = sq_ff;
      out_valid_in = out_valid_ff && rec_stall;
      out_in = out_ff;
      if (p_valid_ff && adv) begin
         lin_in = lin_next; sq_in = sq_next;
         if (p_last_ff) begin
            out_valid_in = 1'b1;
            out_in.minimum  = 16'(p_min_ff);
            out_in.maximum  = 16'(p_max_ff);
            out_in.lin_sum  = lin_next;
            out_in.sq_sum   = sq_next;
            out_in.duration = p_dur_ff;
            if (p_seen_ff < 2'd2) out_in.status = nws_pkg::STATUS_FEW;
            else if (p_back_ff) out_in.status = nws_pkg::STATUS_BACKWARD;
            else if (p_dur_ff == '0) out_in.status = nws_pkg::STATUS_ZERO_DUR;
            else out_in.status = nws_pkg::STATUS_OK;
            lin_in = '0; sq_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0; prev_t_ff <= '0; prev_x_ff <= '0; seen_ff <= '0; back_ff <= 1'b0;
         min_ff <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         max_ff <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         lin_ff <= '0; sq_ff <= '0; p_valid_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         start_ff <= start_in; prev_t_ff <= prev_t_in; prev_x_ff <= prev_x_in;
         seen_ff <= seen_in; back_ff <= back_in; min_ff <= min_in; max_ff <= max_in;
         lin_ff <= lin_in; sq_ff <= sq_in; p_valid_ff <= p_valid_in;
         out_valid_ff <= out_valid_in;
      end
      p_xs_ff <= p_xs_in; p_q_ff <= p_q_in; p_dt_ff <= p_dt_in; p_last_ff <= p_last_in;
      p_seen_ff <= p_seen_in; p_back_ff <= p_back_in; p_dur_ff <= p_dur_in;
      p_min_ff <= p_min_in; p_max_ff <= p_max_in; out_ff <= out_in;
   end
endmodule

// ===== design/nws_back.sv =====
// back end: mean divide and rms divide plus square root, one bit per cycle
module nws_back #(
   parameter int TIME_BITS = nws_pkg::TimeBits
) (
   input  logic clock,
   input  logic reset,
   input  logic rec_valid,
   output logic rec_stall,
   input  nws_pkg::record_type rec_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [15:0] rsp_minimum,
   output logic signed [15:0] rsp_maximum,
   output logic [15:0] rsp_peak_to_peak,
   output logic signed [15:0] rsp_mean_value,
   output logic [15:0] rsp_rms_value,
   output logic [1:0] rsp_status
);
   localparam int LB = nws_pkg::LinBits;
   localparam int SB = nws_pkg::SqBits;
   localparam int DW = TIME_BITS + 2;

   nws_pkg::back_state_type st_ff, st_in;
   nws_pkg::record_type rec_ff, rec_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [LB-1:0] lq_ff, lq_in;   // mean quotient, magnitude
   logic [DW:0] lr_ff, lr_in;
   logic [SB-1:0] sq_ff, sq_in;   // rms quotient
   logic [DW:0] sr_ff, sr_in;
   logic [SB-1:0] rv_ff, rv_in, rt_ff, rt_in;
   logic [SB:0] bit_ff, bit_in;
   logic signed [15:0] mean_ff, mean_in;
   logic [15:0] rms_ff, rms_in;
   logic neg;
   logic [LB-1:0] labs;
   logic [DW:0] d2, d3, lsh, ssh;
   logic [SB:0] trial;

   assign neg = rec_ff.lin_sum[LB-1];
   assign labs = neg ? LB'(-rec_ff.lin_sum) : LB'(rec_ff.lin_sum);
   assign d2 = (DW+1)'({rec_ff.duration, 1'b0});
   assign d3 = d2 + (DW+1)'(rec_ff.duration);
   assign lsh = {lr_ff[DW-1:0], lq_ff[LB-1]};
   assign ssh = {sr_ff[DW-1:0], sq_ff[SB-1]};
   assign trial = (SB+1)'(rt_ff) + bit_ff;
   assign rec_stall = st_ff != nws_pkg::DIV_IDLE;
   assign rsp_valid = st_ff == nws_pkg::DIV_DONE;
   assign rsp_minimum = rec_ff.minimum;
   assign rsp_maximum = rec_ff.maximum;
   assign rsp_peak_to_peak = 16'(rec_ff.maximum - rec_ff.minimum);
   assign rsp_mean_value = mean_ff;
   assign rsp_rms_value = rms_ff;
   assign rsp_status = rec_ff.status;

   always_comb begin
      st_in = st_ff; rec_in = rec_ff; cnt_in = cnt_ff;
      lq_in = lq_ff; lr_in = lr_ff; sq_in = sq_ff; sr_in = sr_ff;
      rv_in = rv_ff; rt_in = rt_ff; bit_in = bit_ff; mean_in = mean_ff; rms_in = rms_ff;
      unique case (st_ff)
         nws_pkg::DIV_IDLE: begin
            if (rec_valid) begin
               rec_in = rec_data; cnt_in = '0; lr_in = '0; sr_in = '0;
               lq_in = '0; sq_in = rec_data.sq_sum; mean_in = '0; rms_in = '0;
               st_in = (rec_data.status == nws_pkg::STATUS_OK) ?
                       nws_pkg::DIV_RUN : nws_pkg::DIV_DONE;
            end
         end
         nws_pkg::DIV_RUN: begin
            if (cnt_ff == 7'd0) lq_in = labs;
            else begin
               // restoring division, both quotients one bit per cycle
               if (lsh >= d2) begin lr_in = lsh - d2; lq_in = {lq_ff[LB-2:0], 1'b1}; end
               else begin lr_in = lsh; lq_in = {lq_ff[LB-2:0], 1'b0}; end
               if (ssh >= d3) begin sr_in = ssh - d3; sq_in = {sq_ff[SB-2:0], 1'b1}; end
               else begin sr_in = ssh; sq_in = {sq_ff[SB-2:0], 1'b0}; end
               if (cnt_ff > 7'(LB)) begin lq_in = lq_ff; lr_in = lr_ff; end
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'(SB)) begin
               mean_in = neg ? 16'(-lq_in) : 16'(lq_in);
               rv_in = sq_in; rt_in = '0; bit_in = (SB+1)'(1) << (SB-2);
               st_in = nws_pkg::DIV_SQRT;
            end
         end
         nws_pkg::DIV_SQRT: begin
            if (bit_ff == '0) begin
               rms_in = 16'(rt_ff); st_in = nws_pkg::DIV_DONE;
            end else begin
               if ((SB+1)'(rv_ff) >= trial) begin
                  rv_in = SB'((SB+1)'(rv_ff) - trial);
                  rt_in = SB'(((SB+1)'(rt_ff) >> 1) + bit_ff);
               end else rt_in = rt_ff >> 1;
               bit_in = bit_ff >> 2;
            end
         end
         nws_pkg::DIV_DONE: if (!rsp_stall) st_in = nws_pkg::DIV_IDLE;
         default: st_in = nws_pkg::DIV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= nws_pkg::DIV_IDLE;
      else st_ff <= st_in;
      rec_ff <= rec_in; cnt_ff <= cnt_in; lq_ff <= lq_in; lr_ff <= lr_in;
      sq_ff <= sq_in; sr_ff <= sr_in; rv_ff <= rv_in; rt_ff <= rt_in;
      bit_ff <= bit_in; mean_ff <= mean_in; rms_ff <= rms_in;
   end
endmodule

// ===== dv/nonuniform_waveform_statistics_tb.sv =====
// testbench for the nonuniform waveform statistics block: predicted records checked word by word
module nonuniform_waveform_statistics_tb;

   // one expected record summary
   typedef struct {
      logic signed [15:0] minimum;
      logic signed [15:0] maximum;
      logic [15:0] peak_to_peak;
      logic signed [15:0] mean_value;
      logic [15:0] rms_value;
      nws_pkg::status_type status;
   } summary_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_sample_time = '0;
   logic signed [15:0] req_sample_value = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_minimum;
   logic signed [15:0] rsp_maximum;
   logic [15:0] rsp_peak_to_peak;
   logic signed [15:0] rsp_mean_value;
   logic [15:0] rsp_rms_value;
   logic [1:0] rsp_status;

   summary_type pending_summaries[$];
   int error_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   bit stall_heavy = 1'b0;

   // predictor state, mirrors the block's record accumulators
   logic [31:0] rec_start;
   logic [31:0] rec_prev_time;
   logic signed [15:0] rec_prev_value;
   int unsigned rec_count;
   logic signed [15:0] rec_min;
   logic signed [15:0] rec_max;
   logic signed [63:0] rec_lin_sum;
   logic [63:0] rec_sq_sum;
   bit rec_backwards;

   nonuniform_waveform_statistics dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample_time(req_sample_time), .req_sample_value(req_sample_value),
      .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_minimum(rsp_minimum), .rsp_maximum(rsp_maximum),
      .rsp_peak_to_peak(rsp_peak_to_peak), .rsp_mean_value(rsp_mean_value),
      .rsp_rms_value(rsp_rms_value), .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   function automatic void clear_record();
      rec_start = '0;
      rec_prev_time = '0;
      rec_prev_value = '0;
      rec_count = 0;
      rec_min = 16'sh7fff;
      rec_max = -16'sh8000;
      rec_lin_sum = '0;
      rec_sq_sum = '0;
      rec_backwards = 1'b0;
   endfunction

   // bitwise integer square root, rounded down
   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitpos;
      root = '0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v = v - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   // fold one sample into the record, queue a summary on the last one
   function automatic void accumulate_sample(logic [31:0] t, logic signed [15:0] x, bit fin);
      logic [63:0] dt;
      logic signed [63:0] x0;
      logic signed [63:0] x1;
      logic [63:0] duration;
      summary_type s;
      x0 = rec_prev_value;
      x1 = x;
      if (rec_count == 0) begin
         rec_start = t;
      end else if (t < rec_prev_time) begin
         rec_backwards = 1'b1;
      end else if (!rec_backwards) begin
         dt = {32'd0, t - rec_prev_time};
         rec_lin_sum = rec_lin_sum + (x0 + x1) * $signed(dt);
         rec_sq_sum = rec_sq_sum + 64'(x0 * x0 + x0 * x1 + x1 * x1) * dt;
      end
      if (x < rec_min) rec_min = x;
      if (x > rec_max) rec_max = x;
      rec_prev_time = t;
      rec_prev_value = x;
      if (rec_count < 2) rec_count++;
      if (!fin) return;
      duration = {32'd0, rec_prev_time - rec_start};
      s.minimum = rec_min;
      s.maximum = rec_max;
      s.peak_to_peak = 16'(rec_max - rec_min);
      s.mean_value = '0;
      s.rms_value = '0;
      if (rec_count < 2) s.status = nws_pkg::STATUS_FEW;
      else if (rec_backwards) s.status = nws_pkg::STATUS_BACKWARD;
      else if (duration == 0) s.status = nws_pkg::STATUS_ZERO_DUR;
      else begin
         s.status = nws_pkg::STATUS_OK;
         // signed divide truncates toward zero
         s.mean_value = 16'(rec_lin_sum / $signed(2 * duration));
         s.rms_value = 16'(floor_root(rec_sq_sum / (3 * duration)));
      end
      pending_summaries.insert(pending_summaries.size(), s);
      clear_record();
   endfunction

   // send one word, with bursty gaps between words
   task automatic send_sample(logic [31:0] t, logic signed [15:0] x, bit fin);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_sample_time <= t;
      req_sample_value <= x;
      req_last <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      accumulate_sample(t, x, fin);
      @(negedge clock);
   endtask

   // random record; mostly rising timestamps, some steps backward or repeated
   task automatic send_record(int unsigned len, bit allow_back, bit wide_time);
      logic [31:0] t;
      logic [31:0] step;
      t = wide_time ? $urandom : $urandom_range(0, 1000);
      for (int unsigned i = 0; i < len; i++) begin
         send_sample(t, 16'($urandom), i == len - 1);
         if (allow_back && $urandom_range(0, 30) == 0) step = -$urandom_range(1, 50);
         else if ($urandom_range(0, 9) == 0) step = 0;
         else if (wide_time) step = $urandom_range(0, 32'h0100_0000);
         else step = $urandom_range(1, 300);
         // keep total span within the time width so the sums stay bounded
         if (!allow_back && 33'(t) + 33'(step) > 33'hffff_ffff) step = 0;
         t = t + step;
      end
   endtask

   task automatic test_directed();
      // single sample, extremes of value
      send_sample(32'd5, 16'sh7fff, 1'b1);
      send_sample(32'hffff_ffff, -16'sh8000, 1'b1);
      // full-scale span across the whole time range
      send_sample(32'd0, -16'sh8000, 1'b0);
      send_sample(32'hffff_ffff, -16'sh8000, 1'b1);
      send_sample(32'd0, 16'sh7fff, 1'b0);
      send_sample(32'hffff_ffff, 16'sh7fff, 1'b1);
      send_sample(32'd0, -16'sh8000, 1'b0);
      send_sample(32'hffff_ffff, 16'sh7fff, 1'b1);
      // zero duration
      send_sample(32'd100, 16'sd3, 1'b0);
      send_sample(32'd100, -16'sd9, 1'b1);
      // time decreasing, sums frozen afterwards
      send_sample(32'd50, 16'sd10, 1'b0);
      send_sample(32'd40, 16'sd20, 1'b0);
      send_sample(32'd90, -16'sd30, 1'b1);
      // negative mean truncation
      send_sample(32'd0, -16'sd1, 1'b0);
      send_sample(32'd3, -16'sd2, 1'b0);
      send_sample(32'd10, 16'sd0, 1'b1);
      // alternating bits
      send_sample(32'haaaa_aaaa, 16'sh5555, 1'b0);
      send_sample(32'hd555_5555, -16'sh5556, 1'b1);
   endtask

   task automatic test_short_records();
      for (int i = 0; i < 150; i++) send_record($urandom_range(1, 4), 1'b1, 1'b0);
   endtask

   task automatic test_long_records();
      for (int i = 0; i < 35; i++) send_record($urandom_range(5, 30), $urandom_range(0, 1), 1'b0);
   endtask

   task automatic test_wide_timestamps();
      for (int i = 0; i < 25; i++) send_record($urandom_range(2, 12), 1'b0, 1'b1);
   endtask

   // receiver stall pattern, alternating calm and heavy phases
   always @(negedge clock) begin
      if (!reset) begin
         if ($urandom_range(0, 99) == 0) stall_heavy <= ~stall_heavy;
         rsp_stall <= stall_heavy ? ($urandom_range(0, 3) != 0) : 1'b0;
      end
   end

   // result checker against the oldest expected summary
   always @(posedge clock) begin
      summary_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_summaries.size() == 0) begin
            $display("%0t: unexpected result word, actual min %0d", $time, rsp_minimum);
            error_count++;
         end else begin
            e = pending_summaries.pop_front();
            if (rsp_minimum !== e.minimum) begin
               $display("%0t: minimum exp %0d act %0d", $time, e.minimum, rsp_minimum);
               error_count++;
            end
            if (rsp_maximum !== e.maximum) begin
               $display("%0t: maximum exp %0d act %0d", $time, e.maximum, rsp_maximum);
               error_count++;
            end
            if (rsp_peak_to_peak !== e.peak_to_peak) begin
               $display("%0t: peak_to_peak exp %0d act %0d", $time, e.peak_to_peak,
                        rsp_peak_to_peak);
               error_count++;
            end
            if (rsp_mean_value !== e.mean_value) begin
               $display("%0t: mean exp %0d act %0d", $time, e.mean_value, rsp_mean_value);
               error_count++;
            end
            if (rsp_rms_value !== e.rms_value) begin
               $display("%0t: rms exp %0d act %0d", $time, e.rms_value, rsp_rms_value);
               error_count++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status exp %0d act %0d", $time, e.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      clear_record();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_short_records();
      test_long_records();
      test_wide_timestamps();
      req_valid <= 1'b0;
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_summaries.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
